>>> hw/rtl/eles_pkg.sv
// Shared types and constants for the element stiffness block.
// No dependencies; imported by every module of the block.
package eles_pkg;

    localparam int GRAD_W  = 32;
    localparam int PROD_W  = 64;
    localparam int COEF_W  = 64;
    localparam int TERM_W  = 128;
    localparam int K_W     = 64;
    localparam int FRAC_SH = 48;
    localparam int NUM_W   = 89;
    localparam int DEN_W   = 33;
    localparam int CNT_W   = 7;
    localparam int LAT     = 7;

    localparam logic [14:0] RATIO_MAX = 15'd32112;
    localparam logic [31:0] E_RESET   = 32'd1000;
    localparam logic [14:0] V_RESET   = 15'd19661;

    localparam logic CFG_YOUNGS  = 1'b0;
    localparam logic CFG_POISSON = 1'b1;

    localparam logic [1:0] SEL_C1 = 2'd0;
    localparam logic [1:0] SEL_C2 = 2'd1;
    localparam logic [1:0] SEL_C3 = 2'd2;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SETUP,
        CS_LOAD,
        CS_DIV
    } coef_state_t;

    typedef struct packed {
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
    } coef_set_t;

endpackage

>>> hw/rtl/eles_coef.sv
// Configuration registers and coefficient unit: one restoring divider,
// one quotient bit a cycle, shared by the three coefficients. Uses eles_pkg.
module eles_coef (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 busy,
    output eles_pkg::coef_set_t  coef
);
    import eles_pkg::*;

    coef_state_t       state_reg, state_next;
    logic [31:0]       e_reg;
    logic [14:0]       v_reg;
    logic [48:0]       n1_reg, n1_next;
    logic [48:0]       n2_reg, n2_next;
    logic [DEN_W-1:0]  d1_reg, d1_next;
    logic [16:0]       d3_reg, d3_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  div_reg, div_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [COEF_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        sel_reg, sel_next;
    coef_set_t         c_reg, c_next;

    logic [14:0]       vc;
    logic [DEN_W:0]    rem_sh;
    logic              qbit;
    logic [33:0]       den_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_SETUP;
            e_reg     <= E_RESET;
            v_reg     <= V_RESET;
            sel_reg   <= SEL_C1;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_index == CFG_YOUNGS)
                e_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_POISSON)
                v_reg <= cfg_data[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        n1_reg  <= n1_next;
        n2_reg  <= n2_next;
        d1_reg  <= d1_next;
        d3_reg  <= d3_next;
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        c_reg   <= c_next;
    end

    always_comb
    begin
        vc       = (v_reg > RATIO_MAX) ? RATIO_MAX : v_reg;
        den_full = ({17'd0, 17'h10000 + {2'b0, vc}})
                 * ({17'd0, 17'h10000 - {1'b0, vc, 1'b0}});
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        qbit     = (rem_sh >= {1'b0, div_reg});
        state_next = state_reg;
        n1_next  = n1_reg;
        n2_next  = n2_reg;
        d1_next  = d1_reg;
        d3_next  = d3_reg;
        num_next = num_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        c_next   = c_reg;
        case (state_reg)
            CS_IDLE:
            begin
            end
            CS_SETUP:
            begin
                n1_next    = 49'(e_reg * (17'h10000 - {2'b0, vc}));
                n2_next    = 49'(e_reg * vc);
                d1_next    = den_full[DEN_W-1:0];
                d3_next    = 17'h10000 + {2'b0, vc};
                sel_next   = SEL_C1;
                state_next = CS_LOAD;
            end
            CS_LOAD:
            begin
                case (sel_reg)
                    SEL_C1:
                    begin
                        num_next = {n1_reg, 40'd0};
                        div_next = d1_reg;
                    end
                    SEL_C2:
                    begin
                        num_next = {n2_reg, 40'd0};
                        div_next = d1_reg;
                    end
                    default:
                    begin
                        num_next = {18'd0, e_reg, 39'd0};
                        div_next = {16'd0, d3_reg};
                    end
                endcase
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = CS_DIV;
            end
            CS_DIV:
            begin
                rem_next = qbit ? DEN_W'(rem_sh - {1'b0, div_reg}) : rem_sh[DEN_W-1:0];
                quo_next = {quo_reg[COEF_W-2:0], qbit};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    case (sel_reg)
                        SEL_C1:  c_next.c1 = quo_next;
                        SEL_C2:  c_next.c2 = quo_next;
                        default: c_next.c3 = quo_next;
                    endcase
                    if (sel_reg == SEL_C3)
                        state_next = CS_IDLE;
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = CS_LOAD;
                    end
                end
            end
            default:
                state_next = CS_IDLE;
        endcase
        if (cfg_valid)
            state_next = CS_SETUP;
    end

    assign busy = (state_reg != CS_IDLE);
    assign coef = c_reg;

endmodule

>>> hw/rtl/eles_term.sv
// One coefficient term: 64x64 magnitude product from four 32x32 partials,
// then the sign. Three register stages. Uses eles_pkg.
module eles_term (
    input  logic                              clk,
    input  logic [eles_pkg::COEF_W-1:0]       coef,
    input  logic [eles_pkg::PROD_W-1:0]       mag,
    input  logic                              neg,
    output logic signed [eles_pkg::TERM_W-1:0] term
);
    import eles_pkg::*;

    logic [63:0]        p00_reg, p01_reg, p10_reg, p11_reg;
    logic               neg1_reg, neg2_reg;
    logic [TERM_W-1:0]  mag_reg;
    logic [TERM_W-1:0]  mag_next;
    logic signed [TERM_W-1:0] term_reg;

    always_comb
    begin
        mag_next = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                 + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
    end

    always_ff @(posedge clk)
    begin
        p00_reg  <= coef[31:0]  * mag[31:0];
        p01_reg  <= coef[31:0]  * mag[63:32];
        p10_reg  <= coef[63:32] * mag[31:0];
        p11_reg  <= coef[63:32] * mag[63:32];
        neg1_reg <= neg;
        mag_reg  <= mag_next;
        neg2_reg <= neg1_reg;
        term_reg <= neg2_reg ? -$signed(mag_reg) : $signed(mag_reg);
    end

    assign term = term_reg;

endmodule

>>> hw/rtl/eles_outsat.sv
// Entry output stage: add the two terms, drop 48 fraction bits, saturate.
// Two register stages. Uses eles_pkg.
module eles_outsat (
    input  logic                               clk,
    input  logic signed [eles_pkg::TERM_W-1:0] term_a,
    input  logic signed [eles_pkg::TERM_W-1:0] term_b,
    output logic signed [eles_pkg::K_W-1:0]    k
);
    import eles_pkg::*;

    localparam int SH_W = TERM_W - FRAC_SH;

    logic signed [TERM_W-1:0] sum_reg;
    logic signed [SH_W-1:0]   sh;
    logic                     over;
    logic signed [K_W-1:0]    k_reg, k_next;

    always_comb
    begin
        sh   = sum_reg[TERM_W-1:FRAC_SH];
        over = !((&sh[SH_W-1:K_W-1]) || !(|sh[SH_W-1:K_W-1]));
        if (over)
            k_next = sh[SH_W-1] ? {1'b1, {(K_W-1){1'b0}}} : {1'b0, {(K_W-1){1'b1}}};
        else
            k_next = sh[K_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= term_a + term_b;
        k_reg   <= k_next;
    end

    assign k = k_reg;

endmodule

>>> hw/rtl/elastic_element_stiffness.sv
// Top level of the element stiffness block: gradient products, operand
// forming, 18 coefficient terms and 9 output stages. Uses eles_pkg, eles_coef,
// eles_term, eles_outsat.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  input    | start, busy            | grad_i_x..z, grad_j_x..z
//  result   | done (strobe)          | k_xx .. k_zz
//  config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// One item per cycle while busy is low; done marks each start's result.
// busy is high after reset and after every configuration write while the
// shared divider rebuilds the coefficients.
// The pipeline never stalls; the receiver takes every result as it comes.
module elastic_element_stiffness (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] grad_i_x,
    input  logic signed [31:0] grad_i_y,
    input  logic signed [31:0] grad_i_z,
    input  logic signed [31:0] grad_j_x,
    input  logic signed [31:0] grad_j_y,
    input  logic signed [31:0] grad_j_z,
    output logic               done,
    output logic signed [63:0] k_xx,
    output logic signed [63:0] k_xy,
    output logic signed [63:0] k_xz,
    output logic signed [63:0] k_yx,
    output logic signed [63:0] k_yy,
    output logic signed [63:0] k_yz,
    output logic signed [63:0] k_zx,
    output logic signed [63:0] k_zy,
    output logic signed [63:0] k_zz,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);
    import eles_pkg::*;

    coef_set_t                 coef;
    logic [LAT-1:0]            vld_reg;
    logic signed [GRAD_W-1:0]  gi [3];
    logic signed [GRAD_W-1:0]  gj [3];
    logic signed [PROD_W-1:0]  p_reg [3][3];
    logic [PROD_W-1:0]         mag_a_reg [9];
    logic [PROD_W-1:0]         mag_b_reg [9];
    logic                      neg_a_reg [9];
    logic                      neg_b_reg [9];
    logic signed [TERM_W-1:0]  t_a [9];
    logic signed [TERM_W-1:0]  t_b [9];
    logic signed [K_W-1:0]     k [9];

    eles_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .coef      (coef)
    );

    assign cfg_ready = 1'b1;

    assign gi[0] = grad_i_x;
    assign gi[1] = grad_i_y;
    assign gi[2] = grad_i_z;
    assign gj[0] = grad_j_x;
    assign gj[1] = grad_j_y;
    assign gj[2] = grad_j_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start && !busy};
    end

    assign done = vld_reg[LAT-1];

    genvar a, b;
    generate
        for (a = 0; a < 3; a++)
        begin : g_row
            for (b = 0; b < 3; b++)
            begin : g_col
                localparam int E = a * 3 + b;
                logic signed [PROD_W:0] op_a, op_b;
                logic [PROD_W:0]        abs_a, abs_b;
                logic [COEF_W-1:0]      c_a;

                always_ff @(posedge clk)
                begin
                    p_reg[a][b] <= gi[a] * gj[b];
                end

                always_comb
                begin
                    if (a == b)
                    begin
                        op_a = (PROD_W + 1)'(p_reg[a][a]);
                        op_b = (PROD_W + 1)'(p_reg[(a + 1) % 3][(a + 1) % 3])
                             + (PROD_W + 1)'(p_reg[(a + 2) % 3][(a + 2) % 3]);
                        c_a  = coef.c1;
                    end
                    else
                    begin
                        op_a = (PROD_W + 1)'(p_reg[a][b]);
                        op_b = (PROD_W + 1)'(p_reg[b][a]);
                        c_a  = coef.c2;
                    end
                    abs_a = op_a[PROD_W] ? -op_a : op_a;
                    abs_b = op_b[PROD_W] ? -op_b : op_b;
                end

                always_ff @(posedge clk)
                begin
                    mag_a_reg[E] <= abs_a[PROD_W-1:0];
                    mag_b_reg[E] <= abs_b[PROD_W-1:0];
                    neg_a_reg[E] <= op_a[PROD_W];
                    neg_b_reg[E] <= op_b[PROD_W];
                end

                eles_term u_term_a (
                    .clk  (clk),
                    .coef (c_a),
                    .mag  (mag_a_reg[E]),
                    .neg  (neg_a_reg[E]),
                    .term (t_a[E])
                );

                eles_term u_term_b (
                    .clk  (clk),
                    .coef (coef.c3),
                    .mag  (mag_b_reg[E]),
                    .neg  (neg_b_reg[E]),
                    .term (t_b[E])
                );

                eles_outsat u_out (
                    .clk    (clk),
                    .term_a (t_a[E]),
                    .term_b (t_b[E]),
                    .k      (k[E])
                );
            end
        end
    endgenerate

    assign k_xx = k[0];
    assign k_xy = k[1];
    assign k_xz = k[2];
    assign k_yx = k[3];
    assign k_yy = k[4];
    assign k_yz = k[5];
    assign k_zx = k[6];
    assign k_zy = k[7];
    assign k_zz = k[8];

endmodule
